### design/bilateral_filter_3d_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bilateral_filter_3d block
// Define NO_ASSERTIONS to compile every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef BILATERAL_FILTER_3D_ASSERT_SVH
`define BILATERAL_FILTER_3D_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge out of reset
`define BF3D_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bilateral_filter_3d: assertion failed");
// Consequent that must hold in the cycle after the antecedent
`define BF3D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bilateral_filter_3d: assertion failed");
`else
`define BF3D_ASSERT(lbl, prop)
`define BF3D_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/bf3d_pkg.sv
// ----------------------------------------------------------------------------
// bf3d_pkg
// Sizes, widths, register indexes and helpers of the 3-D bilateral filter.
// ----------------------------------------------------------------------------
package bf3d_pkg;

    // Volume geometry and neighborhood limit
    localparam int SIZE_X     = 64;
    localparam int SIZE_Y     = 64;
    localparam int SIZE_Z     = 64;
    localparam int MAX_RADIUS = 3;

    // Field widths
    localparam int COORD_W    = 6;
    localparam int VAL_W      = 16;
    localparam int RAD_W      = 2;
    localparam int SC_W       = 16;
    localparam int IC_W       = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Volume store
    localparam int NVOX   = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int VOL_AW = $clog2(NVOX);
    localparam int POS_W  = 12;  // signed neighbor coordinate
    localparam int AXIS_W = 11;  // unsigned coordinate up to 2047

    // Exponential weight table
    localparam int          EXP_SAT   = 4096;
    localparam int          EXP_DEPTH = EXP_SAT + 1;
    localparam int          EXP_AW    = $clog2(EXP_DEPTH);
    localparam int          WGT_W     = 17;
    localparam logic [63:0] EXP_STEP  = 64'd4278222805;
    localparam logic [31:0] EXP_ONE   = 32'h4000_0000;
    localparam logic [63:0] EXP_HALF  = 64'h8000_0000;
    localparam logic [31:0] WGT_HALF  = 32'd8192;
    localparam int          EXP_FRAC  = 14;
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(65536);

    // Offsets and squares
    localparam int MAG_W = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int OFS_W = MAG_W + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SP_W  = SC_W + SQ_W + 2;
    localparam int E_W   = SP_W + 1;
    localparam int IT_SHIFT = 24;

    // Accumulators and divider
    localparam int TAPS   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int TAP_W  = $clog2(TAPS + 1);
    localparam int DEN_W  = WGT_W + TAP_W;
    localparam int NUM_W  = DEN_W + VAL_W + 1;
    localparam int Q_W    = VAL_W + 1;
    localparam int STEP_W = $clog2(Q_W);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS_X        = 3'd0,
        CFG_RADIUS_Y        = 3'd1,
        CFG_RADIUS_Z        = 3'd2,
        CFG_SPATIAL_COEFF_X = 3'd3,
        CFG_SPATIAL_COEFF_Y = 3'd4,
        CFG_SPATIAL_COEFF_Z = 3'd5,
        CFG_INTENSITY_COEFF = 3'd6
    } cfg_idx_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Linear voxel address x + SIZE_X*(y + SIZE_Y*z)
    function automatic logic [VOL_AW-1:0] vox_addr(input logic [AXIS_W-1:0] x,
                                                   input logic [AXIS_W-1:0] y,
                                                   input logic [AXIS_W-1:0] z);
        logic [VOL_AW-1:0] row;
        row = VOL_AW'(y) + VOL_AW'(SIZE_Y) * VOL_AW'(z);
        return VOL_AW'(x) + VOL_AW'(SIZE_X) * row;
    endfunction

endpackage

### design/bf3d_if.sv
// ----------------------------------------------------------------------------
// bf3d_if
// Valid/ready channels of the bilateral filter: request items and results.
// ----------------------------------------------------------------------------
interface bf3d_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [bf3d_pkg::COORD_W-1:0] coord_x;
    logic [bf3d_pkg::COORD_W-1:0] coord_y;
    logic [bf3d_pkg::COORD_W-1:0] coord_z;
    logic [bf3d_pkg::VAL_W-1:0]   voxel_value;

    modport source (output valid, mode, coord_x, coord_y, coord_z, voxel_value, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, coord_z, voxel_value, output ready);
endinterface

interface bf3d_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bf3d_pkg::VAL_W-1:0]   filtered_value;
    logic [bf3d_pkg::COORD_W-1:0] out_x;
    logic [bf3d_pkg::COORD_W-1:0] out_y;
    logic [bf3d_pkg::COORD_W-1:0] out_z;

    modport source (output valid, filtered_value, out_x, out_y, out_z, input ready);
    modport sink   (input valid, filtered_value, out_x, out_y, out_z, output ready);
endinterface

### design/bilateral_filter_3d.sv
// ----------------------------------------------------------------------------
// bilateral_filter_3d
// 3-D bilateral filter over a volume of 16-bit voxels held in one RAM.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields                                         Item
// req      in   mode, coord_x/y/z, voxel_value                 write or filter
// rsp      out  filtered_value, out_x/y/z                      filter result
// cfg      in   cfg_we, cfg_index, cfg_wdata                   register write
//
// After reset the weight table is built, one entry a cycle, with req.ready
// low. A write item inside the volume goes to the volume RAM when accepted.
// A filter item reads the centre voxel, then makes one volume read
// per neighbor offset on the single RAM read port, drains the pipeline, then
// runs a 17-step serial divide. A result waits in the output register; a new item is
// accepted meanwhile, and a following filter result holds until rsp is taken.
// ----------------------------------------------------------------------------
`include "bilateral_filter_3d_assert.svh"

module bilateral_filter_3d (
    input  logic                           clk,
    input  logic                           rst_n,
    bf3d_req_if.sink                       req,
    bf3d_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [bf3d_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bf3d_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bf3d_pkg::*;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_CENTRE = 8'b0000_0100,
        S_CLATCH = 8'b0000_1000,
        S_WALK   = 8'b0001_0000,
        S_DRAIN  = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [RAD_W-1:0] radius_x_reg, radius_y_reg, radius_z_reg;
    logic [SC_W-1:0]  scx_reg, scy_reg, scz_reg;
    logic [IC_W-1:0]  ic_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_x_reg <= RAD_W'(1);
            radius_y_reg <= RAD_W'(1);
            radius_z_reg <= RAD_W'(1);
            scx_reg      <= SC_W'(128);
            scy_reg      <= SC_W'(128);
            scz_reg      <= SC_W'(128);
            ic_reg       <= IC_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RADIUS_X:        radius_x_reg <= cfg_wdata[RAD_W-1:0];
                CFG_RADIUS_Y:        radius_y_reg <= cfg_wdata[RAD_W-1:0];
                CFG_RADIUS_Z:        radius_z_reg <= cfg_wdata[RAD_W-1:0];
                CFG_SPATIAL_COEFF_X: scx_reg      <= cfg_wdata[SC_W-1:0];
                CFG_SPATIAL_COEFF_Y: scy_reg      <= cfg_wdata[SC_W-1:0];
                CFG_SPATIAL_COEFF_Z: scz_reg      <= cfg_wdata[SC_W-1:0];
                CFG_INTENSITY_COEFF: ic_reg       <= cfg_wdata[IC_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp radii to the supported neighborhood
    logic signed [OFS_W-1:0] rx, ry, rz;

    assign rx = (4'(radius_x_reg) > 4'(MAX_RADIUS)) ? OFS_W'(MAX_RADIUS) : OFS_W'(radius_x_reg);
    assign ry = (4'(radius_y_reg) > 4'(MAX_RADIUS)) ? OFS_W'(MAX_RADIUS) : OFS_W'(radius_y_reg);
    assign rz = (4'(radius_z_reg) > 4'(MAX_RADIUS)) ? OFS_W'(MAX_RADIUS) : OFS_W'(radius_z_reg);

    // Request decode
    logic req_acc, req_inside;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_acc    = req.valid && req.ready;
    assign req_inside = (AXIS_W'(req.coord_x) < AXIS_W'(SIZE_X))
                     && (AXIS_W'(req.coord_y) < AXIS_W'(SIZE_Y))
                     && (AXIS_W'(req.coord_z) < AXIS_W'(SIZE_Z));

    // Item coordinates and walk counters
    logic [COORD_W-1:0]      cx_reg, cy_reg, cz_reg;
    logic signed [OFS_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [VAL_W-1:0]        centre_reg;

    logic signed [POS_W-1:0] nx, ny, nz;
    logic                    nb_in, walk_last;
    logic [MAG_W-1:0]        mx, my, mz;

    assign nx = POS_W'(signed'({1'b0, cx_reg})) + POS_W'(dx_reg);
    assign ny = POS_W'(signed'({1'b0, cy_reg})) + POS_W'(dy_reg);
    assign nz = POS_W'(signed'({1'b0, cz_reg})) + POS_W'(dz_reg);

    assign nb_in = !nx[POS_W-1] && (nx < POS_W'(SIZE_X))
                && !ny[POS_W-1] && (ny < POS_W'(SIZE_Y))
                && !nz[POS_W-1] && (nz < POS_W'(SIZE_Z));

    assign walk_last = (dx_reg == rx) && (dy_reg == ry) && (dz_reg == rz);

    assign mx = dx_reg[OFS_W-1] ? MAG_W'(-dx_reg) : MAG_W'(dx_reg);
    assign my = dy_reg[OFS_W-1] ? MAG_W'(-dy_reg) : MAG_W'(dy_reg);
    assign mz = dz_reg[OFS_W-1] ? MAG_W'(-dz_reg) : MAG_W'(dz_reg);

    // Volume store
    logic              vol_we;
    logic [VOL_AW-1:0] vol_waddr, vol_raddr;
    logic [VAL_W-1:0]  vol_rdata;

    assign vol_we    = req_acc && !req.mode && req_inside;
    assign vol_waddr = vox_addr(AXIS_W'(req.coord_x), AXIS_W'(req.coord_y),
                                AXIS_W'(req.coord_z));
    assign vol_raddr = (state_reg == S_CENTRE)
                     ? vox_addr(AXIS_W'(cx_reg), AXIS_W'(cy_reg), AXIS_W'(cz_reg))
                     : vox_addr(nx[AXIS_W-1:0], ny[AXIS_W-1:0], nz[AXIS_W-1:0]);

    bf3d_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NVOX)
    ) u_volume (
        .clk   (clk),
        .we    (vol_we),
        .waddr (vol_waddr),
        .wdata (req.voxel_value),
        .raddr (vol_raddr),
        .rdata (vol_rdata)
    );

    // Weight table
    logic [EXP_AW-1:0] exp_raddr;
    logic [WGT_W-1:0]  exp_rdata;
    logic              tbl_built;

    bf3d_exp_table u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (exp_raddr),
        .rdata (exp_rdata),
        .built (tbl_built)
    );

    // Weight pipeline
    logic                     p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg;
    logic [SQ_W-1:0]          p1_sqx_reg, p1_sqy_reg, p1_sqz_reg;
    logic [31:0]              p2_dsq_reg;
    logic [SP_W-1:0]          p2_sp_reg, p3_sp_reg;
    logic [VAL_W-1:0]         p2_nv_reg, p3_nv_reg, p4_nv_reg;
    logic [63:0]              p3_it_reg;
    logic [WGT_W+VAL_W-1:0]   p5_prod_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [VAL_W-1:0]         diff;
    logic [63:0]              it_sh;
    logic [E_W-1:0]           it_sat, e_sum;
    logic                     pipe_busy;

    assign diff = (vol_rdata > centre_reg) ? vol_rdata - centre_reg : centre_reg - vol_rdata;

    assign it_sh     = p3_it_reg >> IT_SHIFT;
    assign it_sat    = (it_sh > 64'(EXP_SAT)) ? E_W'(EXP_SAT) : E_W'(it_sh);
    assign e_sum     = E_W'(p3_sp_reg) + it_sat;
    assign exp_raddr = (e_sum > E_W'(EXP_SAT)) ? EXP_AW'(EXP_SAT) : EXP_AW'(e_sum);
    assign pipe_busy = p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg || p5_v_reg;

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
        end
        else
        begin
            p1_v_reg <= (state_reg == S_WALK) && nb_in;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
        end
    end

    // Stage payloads: squares, intensity product, weight times value
    always_ff @(posedge clk)
    begin
        p1_sqx_reg  <= SQ_W'(mx) * SQ_W'(mx);
        p1_sqy_reg  <= SQ_W'(my) * SQ_W'(my);
        p1_sqz_reg  <= SQ_W'(mz) * SQ_W'(mz);
        p2_dsq_reg  <= 32'(diff) * 32'(diff);
        p2_sp_reg   <= SP_W'(scx_reg) * SP_W'(p1_sqx_reg)
                     + SP_W'(scy_reg) * SP_W'(p1_sqy_reg)
                     + SP_W'(scz_reg) * SP_W'(p1_sqz_reg);
        p2_nv_reg   <= vol_rdata;
        p3_it_reg   <= 64'(ic_reg) * 64'(p2_dsq_reg);
        p3_sp_reg   <= p2_sp_reg;
        p3_nv_reg   <= p2_nv_reg;
        p4_nv_reg   <= p3_nv_reg;
        p5_prod_reg <= (WGT_W+VAL_W)'(exp_rdata) * (WGT_W+VAL_W)'(p4_nv_reg);
    end

    // Accumulate weights and weighted values
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLATCH)
        begin
            den_reg <= '0;
            num_reg <= '0;
        end
        else
        begin
            if (p4_v_reg)
            begin
                den_reg <= den_reg + DEN_W'(exp_rdata);
            end
            if (p5_v_reg)
            begin
                num_reg <= num_reg + NUM_W'(p5_prod_reg);
            end
        end
    end

    // Rounded mean
    logic             div_start;
    logic [Q_W-1:0]   div_q;
    div_stat_t        div_stat;
    logic [NUM_W-1:0] dividend;

    assign div_start = (state_reg == S_DRAIN) && !pipe_busy;
    assign dividend  = num_reg + NUM_W'(den_reg >> 1);

    bf3d_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // Sequencer
    logic rsp_free;

    assign rsp_free = !rsp.valid || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:   if (tbl_built) state_next = S_IDLE;
            S_IDLE:
            begin
                if (req_acc && req.mode)
                begin
                    state_next = req_inside ? S_CENTRE : S_DONE;
                end
            end
            S_CENTRE: state_next = S_CLATCH;
            S_CLATCH: state_next = S_WALK;
            S_WALK:   if (walk_last) state_next = S_DRAIN;
            S_DRAIN:  if (!pipe_busy) state_next = S_DIV;
            S_DIV:    if (div_stat.done) state_next = S_DONE;
            S_DONE:   if (rsp_free) state_next = S_IDLE;
            default:  state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold item coordinates, step the offset walk, latch the result
    logic [VAL_W-1:0] res_reg;

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            cx_reg  <= req.coord_x;
            cy_reg  <= req.coord_y;
            cz_reg  <= req.coord_z;
            res_reg <= '0;
        end
        if (state_reg == S_CLATCH)
        begin
            centre_reg <= vol_rdata;
            dx_reg     <= -rx;
            dy_reg     <= -ry;
            dz_reg     <= -rz;
        end
        else if (state_reg == S_WALK)
        begin
            if (dx_reg != rx)
            begin
                dx_reg <= dx_reg + 1'b1;
            end
            else
            begin
                dx_reg <= -rx;
                if (dy_reg != ry)
                begin
                    dy_reg <= dy_reg + 1'b1;
                end
                else
                begin
                    dy_reg <= -ry;
                    dz_reg <= dz_reg + 1'b1;
                end
            end
        end
        if ((state_reg == S_DIV) && div_stat.done)
        begin
            res_reg <= div_q[Q_W-1] ? '1 : div_q[VAL_W-1:0];
        end
    end

    // Output register
    logic               rsp_v_reg;
    logic [VAL_W-1:0]   rsp_val_reg;
    logic [COORD_W-1:0] rsp_x_reg, rsp_y_reg, rsp_z_reg;
    logic               rsp_load;

    assign rsp_load = (state_reg == S_DONE) && rsp_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_v_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_v_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_val_reg <= res_reg;
            rsp_x_reg   <= cx_reg;
            rsp_y_reg   <= cy_reg;
            rsp_z_reg   <= cz_reg;
        end
    end

    assign rsp.valid          = rsp_v_reg;
    assign rsp.filtered_value = rsp_val_reg;
    assign rsp.out_x          = rsp_x_reg;
    assign rsp.out_y          = rsp_y_reg;
    assign rsp.out_z          = rsp_z_reg;

    // The centre tap alone carries weight one, so the divisor is never zero
    `BF3D_ASSERT(a_den_has_centre, div_start |-> (den_reg >= DEN_W'(WGT_ONE)))
    // No item enters while neighbor reads or the divide are in flight
    `BF3D_ASSERT(a_no_accept_busy, (pipe_busy || div_stat.busy) |-> !req_acc)
    // Accumulation only happens while walking or draining
    `BF3D_ASSERT(a_acc_in_walk, p5_v_reg |-> (state_reg == S_WALK || state_reg == S_DRAIN))
    // A divider start is followed by a busy divider and the sequencer in the divide state
    `BF3D_ASSERT_NEXT(a_div_follows, div_start, div_stat.busy && state_reg == S_DIV)
endmodule

### design/bf3d_ram.sv
// ----------------------------------------------------------------------------
// bf3d_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bf3d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and register the read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### design/bf3d_exp_table.sv
// ----------------------------------------------------------------------------
// bf3d_exp_table
// Builds the exp(-e/256) weight table after reset, then serves reads.
// ----------------------------------------------------------------------------
module bf3d_exp_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bf3d_pkg::EXP_AW-1:0] raddr,
    output logic [bf3d_pkg::WGT_W-1:0]  rdata,
    output logic                        built
);
    import bf3d_pkg::*;

    logic [31:0]       t_reg;
    logic [31:0]       t_next;
    logic [EXP_AW-1:0] cnt_reg;
    logic              built_reg;
    logic [WGT_W-1:0]  wgt;
    logic [63:0]       prod;
    logic [31:0]       wsum;

    // Next table entry: round(t * exp(-1/256))
    assign prod   = 64'(t_reg) * EXP_STEP + EXP_HALF;
    assign t_next = prod[63:32];

    // Q0.30 to Q0.16 with rounding
    assign wsum = t_reg + WGT_HALF;
    assign wgt  = WGT_W'(wsum >> EXP_FRAC);

    // Sweep one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg     <= EXP_ONE;
            cnt_reg   <= '0;
            built_reg <= 1'b0;
        end
        else if (!built_reg)
        begin
            t_reg   <= t_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == EXP_AW'(EXP_SAT))
            begin
                built_reg <= 1'b1;
            end
        end
    end

    bf3d_ram #(
        .WIDTH (WGT_W),
        .DEPTH (EXP_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (!built_reg),
        .waddr (cnt_reg),
        .wdata (wgt),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign built = built_reg;
endmodule

### design/bf3d_div.sv
// ----------------------------------------------------------------------------
// bf3d_div
// Restoring divider, one quotient bit per cycle, quotient below 2^Q_W.
// ----------------------------------------------------------------------------
module bf3d_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bf3d_pkg::NUM_W-1:0] dividend,
    input  logic [bf3d_pkg::DEN_W-1:0] divisor,
    output logic [bf3d_pkg::Q_W-1:0]   quotient,
    output bf3d_pkg::div_stat_t        stat
);
    import bf3d_pkg::*;

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [Q_W-1:0]    q_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    assign fits = (rem_reg >= dsh_reg);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(Q_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: compare, subtract, shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= NUM_W'(divisor) << (Q_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

### bench/tb_bilateral_filter_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilateral_filter_3d
// Self-checking bench for the 3-D bilateral filter. Voxel writes and filter
// requests go in over the request channel. A behavioral predictor keeps its
// own voxel store, register set and weight table. Each filter result is
// compared against the predictor field by field, in order of arrival.
// ----------------------------------------------------------------------------
module tb_bilateral_filter_3d;
    import bf3d_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int SETTLE_CYCLES   = 400;
    localparam int HOLD_CYCLES     = 3000;
    localparam int PHASES          = 5;
    localparam int PHASE_ITEMS     = 100;
    localparam int CUBE            = 5;
    localparam logic MODE_WRITE    = 1'b0;
    localparam logic MODE_FILTER   = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } voxel_result_t;

    typedef struct {
        logic               mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [VAL_W-1:0]   value;
        bit                 known;
        logic [VAL_W-1:0]   known_value;
    } request_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bf3d_req_if req ();
    bf3d_rsp_if rsp ();

    bilateral_filter_3d dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state
    logic [VAL_W-1:0]  voxel_mem [int];
    longint unsigned   exp_curve [EXP_SAT+1];
    int unsigned       reg_val [7];
    voxel_result_t     pending_results [$];

    int errors;
    int send_idle_pct;
    int rsp_stall_pct;
    int phase_num;
    int hold_left;
    bit hold_done;
    int quiet_cycles;

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Weight table: exp(-e/256) in Q0.30, stepped by exp(-1/256) in Q0.32
    function automatic void build_exp_curve();
        exp_curve[0] = 64'd1 << 30;
        for (int i = 1; i <= EXP_SAT; i++)
            exp_curve[i] = (exp_curve[i-1] * 64'd4278222805 + 64'h8000_0000) >> 32;
    endfunction

    function automatic int vox_key(int x, int y, int z);
        return x + SIZE_X * (y + SIZE_Y * z);
    endfunction

    // Bilateral weighted mean around one voxel
    function automatic logic [VAL_W-1:0] bilateral_mean(int cx, int cy, int cz);
        longint unsigned num, den, e, it, w, res;
        int rx, ry, rz, nx, ny, nz;
        int unsigned centre, nv, diff;
        num = 0;
        den = 0;
        rx = reg_val[CFG_RADIUS_X];
        ry = reg_val[CFG_RADIUS_Y];
        rz = reg_val[CFG_RADIUS_Z];
        centre = voxel_mem[vox_key(cx, cy, cz)];
        for (int dz = -rz; dz <= rz; dz++) begin
            nz = cz + dz;
            if (nz < 0 || nz >= SIZE_Z) continue;
            for (int dy = -ry; dy <= ry; dy++) begin
                ny = cy + dy;
                if (ny < 0 || ny >= SIZE_Y) continue;
                for (int dx = -rx; dx <= rx; dx++) begin
                    nx = cx + dx;
                    if (nx < 0 || nx >= SIZE_X) continue;
                    nv = voxel_mem[vox_key(nx, ny, nz)];
                    diff = (nv > centre) ? nv - centre : centre - nv;
                    e = longint'(reg_val[CFG_SPATIAL_COEFF_X]) * (dx * dx)
                      + longint'(reg_val[CFG_SPATIAL_COEFF_Y]) * (dy * dy)
                      + longint'(reg_val[CFG_SPATIAL_COEFF_Z]) * (dz * dz);
                    it = (longint'(reg_val[CFG_INTENSITY_COEFF])
                          * (longint'(diff) * diff)) >> 24;
                    if (it > EXP_SAT) it = EXP_SAT;
                    e += it;
                    if (e > EXP_SAT) e = EXP_SAT;
                    w = (exp_curve[e] + 8192) >> 14;
                    den += w;
                    num += w * nv;
                end
            end
        end
        res = (num + den / 2) / den;
        if (res > 65535) res = 65535;
        return res[VAL_W-1:0];
    endfunction

    // Write all registers back to back, with no items in flight
    task automatic load_registers(input int unsigned vals [7]);
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            reg_val[i] = vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Offer one item, hold it until taken, then predict its result
    task automatic send_request(input request_row_t r);
        voxel_result_t exp_res;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req.valid       <= 1'b1;
        req.mode        <= r.mode;
        req.coord_x     <= r.x;
        req.coord_y     <= r.y;
        req.coord_z     <= r.z;
        req.voxel_value <= r.value;
        do
            @(posedge clk);
        while (!req.ready);
        if (r.mode == MODE_WRITE) begin
            voxel_mem[vox_key(r.x, r.y, r.z)] = r.value;
        end
        else begin
            exp_res.x = r.x;
            exp_res.y = r.y;
            exp_res.z = r.z;
            exp_res.value = r.known ? r.known_value : bilateral_mean(r.x, r.y, r.z);
            pending_results.push_back(exp_res);
        end
    endtask

    // Drop valid and wait for every outstanding result, then let the block settle
    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random item: filters inside the two fully written corners, writes mostly inside them
    function automatic request_row_t random_request();
        request_row_t r;
        int lo;
        int base;
        lo = ($urandom_range(1) == 0) ? 0 : SIZE_X - CUBE;
        r.known = 0;
        r.known_value = '0;
        if ($urandom_range(99) < 45) begin
            r.mode = MODE_WRITE;
            if ($urandom_range(99) < 20) begin
                r.x = COORD_W'($urandom);
                r.y = COORD_W'($urandom);
                r.z = COORD_W'($urandom);
            end
            else begin
                r.x = COORD_W'(lo + $urandom_range(CUBE - 1));
                r.y = COORD_W'(lo + $urandom_range(CUBE - 1));
                r.z = COORD_W'(lo + $urandom_range(CUBE - 1));
            end
            base = $urandom_range(65535 - 511);
            r.value = ($urandom_range(1) == 0) ? VAL_W'($urandom)
                                              : VAL_W'(base + $urandom_range(511));
        end
        else begin
            r.mode  = MODE_FILTER;
            r.value = VAL_W'($urandom);
            r.x = COORD_W'((lo == 0) ? $urandom_range(1) : SIZE_X - 2 + $urandom_range(1));
            r.y = COORD_W'((lo == 0) ? $urandom_range(1) : SIZE_Y - 2 + $urandom_range(1));
            r.z = COORD_W'((lo == 0) ? $urandom_range(1) : SIZE_Z - 2 + $urandom_range(1));
        end
        return r;
    endfunction

    // Result side: check each accepted item, drive ready with stalls and hold-off
    always @(posedge clk) begin
        voxel_result_t got, want;
        if (rst_n) begin
            if (rsp.valid && rsp.ready) begin
                got.value = rsp.filtered_value;
                got.x = rsp.out_x;
                got.y = rsp.out_y;
                got.z = rsp.out_z;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    errors++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (got.value !== want.value) begin
                        $display("%0t: filtered_value mismatch, expected %h, actual %h",
                                 $time, want.value, got.value);
                        errors++;
                    end
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                        $display("%0t: coordinates mismatch, expected %h/%h/%h, actual %h/%h/%h",
                                 $time, want.x, want.y, want.z, got.x, got.y, got.z);
                        errors++;
                    end
                end
            end
            if (phase_num == 3 && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else begin
                rsp.ready <= !(rsp_stall_pct > 0 && $urandom_range(99) < rsp_stall_pct);
            end
        end
        else begin
            rsp.ready <= 1'b0;
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles > WATCHDOG_CYCLES + EXP_DEPTH) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        request_row_t rows [$];
        request_row_t r;
        int unsigned regs [7];
        int unsigned phase_regs [4][7];
        int phase_idle [PHASES];
        int phase_stall [PHASES];
        int lo;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.mode = MODE_WRITE;
        req.coord_x = '0;
        req.coord_y = '0;
        req.coord_z = '0;
        req.voxel_value = '0;
        errors = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        phase_num = -1;
        hold_left = 0;
        hold_done = 0;
        quiet_cycles = 0;
        build_exp_curve();
        reg_val = '{1, 1, 1, 128, 128, 128, 65536};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: radius 0, so a filter returns the centre voxel itself
        regs = '{0, 0, 0, 128, 128, 128, 65536};
        load_registers(regs);
        rows = '{
            '{MODE_WRITE,  0,  0,  0, 16'hFFFF, 0, 0},
            '{MODE_FILTER, 0,  0,  0, 16'h0000, 1, 16'hFFFF},
            '{MODE_WRITE,  63, 63, 63, 16'h0000, 0, 0},
            '{MODE_FILTER, 63, 63, 63, 16'hFFFF, 1, 16'h0000},
            '{MODE_WRITE,  63, 0,  63, 16'h5555, 0, 0},
            '{MODE_FILTER, 63, 0,  63, 16'h0000, 1, 16'h5555},
            '{MODE_WRITE,  0,  63, 0,  16'hAAAA, 0, 0},
            '{MODE_FILTER, 0,  63, 0,  16'hFFFF, 1, 16'hAAAA},
            '{MODE_WRITE,  0,  0,  0,  16'h0001, 0, 0},
            '{MODE_FILTER, 0,  0,  0,  16'h0000, 1, 16'h0001},
            '{MODE_WRITE,  42, 21, 42, 16'h8000, 0, 0},
            '{MODE_FILTER, 42, 21, 42, 16'h7FFF, 1, 16'h8000}
        };
        foreach (rows[i])
            send_request(rows[i]);

        // Fill both corner cubes so any radius stays on written voxels
        for (int c = 0; c < 2; c++) begin
            lo = (c == 0) ? 0 : SIZE_X - CUBE;
            for (int z = 0; z < CUBE; z++)
                for (int y = 0; y < CUBE; y++)
                    for (int x = 0; x < CUBE; x++) begin
                        r.mode = MODE_WRITE;
                        r.x = COORD_W'(lo + x);
                        r.y = COORD_W'(lo + y);
                        r.z = COORD_W'(lo + z);
                        r.value = (c == 0) ? VAL_W'(16'h4000 + $urandom_range(255))
                                           : VAL_W'($urandom);
                        r.known = 0;
                        r.known_value = '0;
                        send_request(r);
                    end
        end

        // Random phases with different settings and handshake pressure
        phase_regs[0] = '{3, 3, 3, 0, 0, 0, 0};
        phase_regs[1] = '{1, 2, 3, 128, 64, 32, 65536};
        phase_regs[2] = '{0, 3, 1, 65535, 1, 300, 32'hFFFF_FFFF};
        phase_regs[3] = '{2, 0, 3, 200, 200, 200, 16};
        phase_idle  = '{0, 52, 0, 27, 0};
        phase_stall = '{0, 0, 52, 27, 0};
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            if (p < 4)
                regs = phase_regs[p];
            else
                regs = '{$urandom_range(3), $urandom_range(3), $urandom_range(3),
                         $urandom_range(511), $urandom_range(511), $urandom_range(511),
                         $urandom_range(1 << 20)};
            load_registers(regs);
            send_idle_pct <= phase_idle[p];
            rsp_stall_pct <= phase_stall[p];
            phase_num <= p;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request());
        end

        drain_results();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### bilateral_filter_3d.f
+incdir+design
design/bf3d_pkg.sv
design/bf3d_if.sv
design/bf3d_ram.sv
design/bf3d_exp_table.sv
design/bf3d_div.sv
design/bilateral_filter_3d.sv
bench/tb_bilateral_filter_3d.sv
